@@ hdl/gam_pkg.sv @@
// Package for the grouped affine minimum evaluator.
// Holds the payload structs, command and register codes, and the saturation helper.
// No dependencies.
package gam_pkg;

    localparam logic [1:0] OP_LOAD_ROW   = 2'd0;
    localparam logic [1:0] OP_LOAD_GROUP = 2'd1;
    localparam logic [1:0] OP_EVAL       = 2'd2;
    localparam logic [1:0] OP_RESERVED   = 2'd3;

    localparam logic [1:0] REG_GROUPS_IN_USE   = 2'd0;
    localparam logic [1:0] REG_SLICE_CENTER    = 2'd1;
    localparam logic [1:0] REG_SLICE_GENERATOR = 2'd2;

    localparam logic [31:0] GEN_RESET = 32'd65536;
    localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [9:0]         entry_index;
        logic signed [31:0] coef_a;
        logic signed [31:0] offset_b;
        logic [9:0]         group_first_row;
        logic [10:0]        group_row_count;
        logic signed [31:0] eval_value;
    } gam_in_t;

    typedef struct packed {
        logic [5:0]         group_number;
        logic signed [31:0] constraint_value;
        logic signed [31:0] gradient;
        logic [9:0]         min_row_index;
        logic               empty_group;
        logic               last;
    } gam_out_t;

    typedef enum logic [1:0] {
        CMD_ROW,
        CMD_GROUP,
        CMD_EVAL
    } gam_kind_t;

    typedef struct packed {
        gam_kind_t          kind;
        logic [9:0]         idx;
        logic signed [31:0] coef_a;
        logic signed [31:0] offset_b;
        logic [9:0]         first_row;
        logic [10:0]        row_count;
        logic signed [31:0] value;
    } gam_cmd_t;

    typedef struct packed {
        logic [6:0]         groups_in_use;
        logic signed [31:0] slice_center;
        logic signed [31:0] slice_generator;
    } gam_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GRP_RD,
        ST_GRP_DATA,
        ST_WRAP,
        ST_ROW_RD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_CMP,
        ST_GRAD_GO,
        ST_GRAD_WAIT,
        ST_EMIT
    } gam_state_t;

    // Saturates a 65-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
        logic fits;
        begin
            fits = (x[64:31] == {34{1'b0}}) || (x[64:31] == {34{1'b1}});
            if (fits) begin
                sat32 = x[31:0];
            end else if (x[64]) begin
                sat32 = VALUE_MIN;
            end else begin
                sat32 = VALUE_MAX;
            end
        end
    endfunction

endpackage

@@ hdl/grouped_affine_min_eval.sv @@
// Top level of the grouped affine minimum evaluator.
// Depends on gam_pkg, gam_front, gam_back (and gam_divider below it).
//
// Usage: items enter on s_valid/s_ready/s_data; results leave on m_valid/m_ready/m_data.
// A load-row or load-group item writes one table entry and gives no result. An evaluate
// item gives one result per group in use, the final one with last set. The registers
// groups_in_use, slice_center and slice_generator are written through cfg_wr_en,
// cfg_index and cfg_wr_data by the user, only while the block is idle (not enforced).
// A short command queue sits between the input side and the execution side, so the
// input accepts up to two items ahead of the one being executed.
// Each row of a group goes through the two-pass multiply and the 64-step shared divider;
// each non-empty group adds a gradient division on that divider, and an empty group
// skips both. A load is handled in the idle state of the execution side, which takes no
// new command until the last result of an evaluation has been emitted.
// Reset clears the queue, the state machine and the registers; table contents are
// undefined until loaded. When the receiver stalls, the result holds in the output
// register and the execution side waits before the next result.
module grouped_affine_min_eval #(
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_GROUPS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gam_pkg::gam_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output gam_pkg::gam_out_t m_data,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_wr_data
);

    gam_pkg::gam_cfg_t cfg_reg;
    logic              cmd_valid, cmd_pop;
    gam_pkg::gam_cmd_t cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.groups_in_use   <= 7'd0;
            cfg_reg.slice_center    <= 32'sd0;
            cfg_reg.slice_generator <= gam_pkg::GEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gam_pkg::REG_GROUPS_IN_USE:   cfg_reg.groups_in_use   <= cfg_wr_data[6:0];
                gam_pkg::REG_SLICE_CENTER:    cfg_reg.slice_center    <= cfg_wr_data;
                gam_pkg::REG_SLICE_GENERATOR: cfg_reg.slice_generator <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    gam_front #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_GROUPS (MAX_GROUPS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    gam_back #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_GROUPS (MAX_GROUPS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ hdl/gam_divider.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// A zero divisor gives a zero quotient. Depends on nothing but the clock and reset.
module gam_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [63:0] quo
);

    logic [63:0] dvd_reg, dvd_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg;
    logic        neg_reg;
    logic        zero_reg;
    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [32:0] rem_shift;
    logic        ge;

    assign rem_shift = {rem_reg, dvd_reg[63]};
    assign ge        = rem_shift >= {1'b0, den_reg};

    always_comb begin
        dvd_next  = {dvd_reg[62:0], ge};
        rem_next  = ge ? 32'(rem_shift - {1'b0, den_reg}) : rem_shift[31:0];
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (busy_reg) begin
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
            done     <= 1'b0;
        end else begin
            done <= busy_reg && (cnt_reg == 7'd63);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end else begin
                busy_reg <= busy_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg  <= num[63] ? 64'(-num) : num;
            den_reg  <= den[31] ? 32'(-den) : den;
            rem_reg  <= 32'd0;
            neg_reg  <= num[63] ^ den[31];
            zero_reg <= (den == 32'sd0);
        end else if (busy_reg) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign quo = zero_reg ? 64'sd0 : (neg_reg ? 64'(-dvd_reg) : dvd_reg);

endmodule

@@ hdl/gam_front.sv @@
// Input side: accepts items, drops reserved opcodes and out-of-table loads,
// and queues the rest as commands. Depends on gam_pkg.
module gam_front #(
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_GROUPS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gam_pkg::gam_in_t  s_data,
    output logic              cmd_valid,
    output gam_pkg::gam_cmd_t cmd,
    input  logic              cmd_pop
);

    localparam logic [31:0] ROWS_W   = 32'(MAX_ROWS);
    localparam logic [31:0] GROUPS_W = 32'(MAX_GROUPS);

    gam_pkg::gam_cmd_t q_mem [2];
    logic              wp_reg, rp_reg;
    logic [1:0]        cnt_reg, cnt_next;
    gam_pkg::gam_cmd_t cls;
    logic              keep;
    logic              push;

    always_comb begin
        cls.kind      = gam_pkg::CMD_EVAL;
        cls.idx       = s_data.entry_index;
        cls.coef_a    = s_data.coef_a;
        cls.offset_b  = s_data.offset_b;
        cls.first_row = s_data.group_first_row;
        cls.row_count = s_data.group_row_count;
        cls.value     = s_data.eval_value;
        keep          = 1'b0;
        unique case (s_data.opcode)
            gam_pkg::OP_LOAD_ROW: begin
                cls.kind = gam_pkg::CMD_ROW;
                keep     = {22'd0, s_data.entry_index} < ROWS_W;
            end
            gam_pkg::OP_LOAD_GROUP: begin
                cls.kind = gam_pkg::CMD_GROUP;
                keep     = {22'd0, s_data.entry_index} < GROUPS_W;
            end
            gam_pkg::OP_EVAL: begin
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready   = (cnt_reg != 2'd2);
    assign push      = s_valid && s_ready && keep;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_mem[rp_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !cmd_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!push && cmd_pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wp_reg <= ~wp_reg;
            end
            if (cmd_pop) begin
                rp_reg <= ~rp_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wp_reg] <= cls;
        end
    end

endmodule

@@ hdl/gam_back.sv @@
// Execution side: holds the row and group tables, walks each group's rows through
// a shared multiplier and divider, and registers each result. Depends on gam_pkg, gam_divider.
module gam_back #(
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_GROUPS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  gam_pkg::gam_cfg_t cfg,
    input  logic              cmd_valid,
    input  gam_pkg::gam_cmd_t cmd,
    output logic              cmd_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output gam_pkg::gam_out_t m_data
);

    localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int GAW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int PW  = (RAW > 10) ? RAW : 10;
    localparam logic [PW:0]   ROWS_P   = (PW + 1)'(MAX_ROWS);
    localparam logic [PW-1:0] LAST_ROW = PW'(MAX_ROWS - 1);
    localparam logic [6:0]    GROUPS_P = 7'(MAX_GROUPS);

    gam_pkg::gam_state_t state_reg, state_next;

    logic [63:0] row_mem [MAX_ROWS];
    logic [20:0] grp_mem [MAX_GROUPS];
    logic [63:0] row_q;
    logic [20:0] grp_q;

    logic signed [32:0] d_reg;
    logic [6:0]         ng_reg, g_reg, ng_clamp;
    logic [PW-1:0]      ptr_reg, min_row_reg;
    logic [10:0]        remain_reg;
    logic               have_reg, empty_reg;
    logic signed [31:0] a_reg, b_reg, min_a_reg, grad_reg;
    logic signed [48:0] prod_reg;
    logic signed [63:0] num_reg;
    logic signed [64:0] v_reg, best_reg;

    logic signed [31:0] a_op, row_a, row_b;
    logic signed [16:0] mul_b;
    logic signed [48:0] mul_p;
    logic               div_start, div_done;
    logic signed [63:0] div_num, div_quo, grad_num;
    logic               emit_fire, out_free, ptr_hi, row_wr, grp_wr;
    logic               better;
    gam_pkg::gam_out_t  m_data_reg;
    logic               m_valid_reg;

    assign row_a    = row_q[63:32];
    assign row_b    = row_q[31:0];
    assign ng_clamp = (cfg.groups_in_use > GROUPS_P) ? GROUPS_P : cfg.groups_in_use;
    assign out_free = !m_valid_reg || m_ready;
    assign ptr_hi   = {1'b0, ptr_reg} >= ROWS_P;
    assign better   = !have_reg || (v_reg < best_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gam_pkg::ST_IDLE: begin
                if (cmd_valid && cmd.kind == gam_pkg::CMD_EVAL && ng_clamp != 7'd0) begin
                    state_next = gam_pkg::ST_GRP_RD;
                end
            end
            gam_pkg::ST_GRP_RD:   state_next = gam_pkg::ST_GRP_DATA;
            gam_pkg::ST_GRP_DATA: begin
                state_next = (grp_q[10:0] == 11'd0) ? gam_pkg::ST_EMIT : gam_pkg::ST_WRAP;
            end
            gam_pkg::ST_WRAP: begin
                if (!ptr_hi) begin
                    state_next = gam_pkg::ST_ROW_RD;
                end
            end
            gam_pkg::ST_ROW_RD:  state_next = gam_pkg::ST_MUL_LO;
            gam_pkg::ST_MUL_LO:  state_next = gam_pkg::ST_MUL_HI;
            gam_pkg::ST_MUL_HI:  state_next = gam_pkg::ST_DIV_GO;
            gam_pkg::ST_DIV_GO:  state_next = gam_pkg::ST_DIV_WAIT;
            gam_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = gam_pkg::ST_CMP;
                end
            end
            gam_pkg::ST_CMP: begin
                state_next = (remain_reg == 11'd1) ? gam_pkg::ST_GRAD_GO : gam_pkg::ST_ROW_RD;
            end
            gam_pkg::ST_GRAD_GO: state_next = gam_pkg::ST_GRAD_WAIT;
            gam_pkg::ST_GRAD_WAIT: begin
                if (div_done) begin
                    state_next = gam_pkg::ST_EMIT;
                end
            end
            gam_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = (g_reg + 7'd1 == ng_reg) ? gam_pkg::ST_IDLE : gam_pkg::ST_GRP_RD;
                end
            end
            default: state_next = gam_pkg::ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        cmd_pop   = 1'b0;
        row_wr    = 1'b0;
        grp_wr    = 1'b0;
        div_start = 1'b0;
        emit_fire = 1'b0;
        unique case (state_reg)
            gam_pkg::ST_IDLE: begin
                cmd_pop = cmd_valid;
                row_wr  = cmd_valid && cmd.kind == gam_pkg::CMD_ROW;
                grp_wr  = cmd_valid && cmd.kind == gam_pkg::CMD_GROUP;
            end
            gam_pkg::ST_DIV_GO, gam_pkg::ST_GRAD_GO: div_start = 1'b1;
            gam_pkg::ST_EMIT: emit_fire = out_free;
            default: begin
            end
        endcase
    end

    // One 32x17 multiplier used twice: low half of the offset, then the high half.
    assign a_op  = (state_reg == gam_pkg::ST_MUL_LO) ? row_a : a_reg;
    assign mul_b = (state_reg == gam_pkg::ST_MUL_LO) ? $signed({1'b0, d_reg[15:0]})
                                                     : d_reg[32:16];
    assign mul_p = a_op * mul_b;

    assign grad_num = -({{16{min_a_reg[31]}}, min_a_reg, 16'd0});
    assign div_num  = (state_reg == gam_pkg::ST_GRAD_GO) ? grad_num : num_reg;

    gam_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (cfg.slice_generator),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (row_wr) begin
            row_mem[RAW'(cmd.idx)] <= {cmd.coef_a, cmd.offset_b};
        end
        row_q <= row_mem[ptr_reg[RAW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (grp_wr) begin
            grp_mem[GAW'(cmd.idx)] <= {cmd.first_row, cmd.row_count};
        end
        grp_q <= grp_mem[g_reg[GAW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gam_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            gam_pkg::ST_IDLE: begin
                d_reg  <= 33'(cmd.value) - 33'(cfg.slice_center);
                ng_reg <= ng_clamp;
                g_reg  <= 7'd0;
            end
            gam_pkg::ST_GRP_DATA: begin
                ptr_reg    <= PW'(grp_q[20:11]);
                remain_reg <= grp_q[10:0];
                have_reg   <= 1'b0;
                empty_reg  <= (grp_q[10:0] == 11'd0);
            end
            gam_pkg::ST_WRAP: begin
                if (ptr_hi) begin
                    ptr_reg <= ptr_reg - ROWS_P[PW-1:0];
                end
            end
            gam_pkg::ST_MUL_LO: begin
                a_reg    <= row_a;
                b_reg    <= row_b;
                prod_reg <= mul_p;
            end
            gam_pkg::ST_MUL_HI: begin
                num_reg <= {{15{prod_reg[48]}}, prod_reg}
                         + {mul_p[47:0], 16'd0};
            end
            gam_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    v_reg <= 65'(b_reg) - 65'(div_quo);
                end
            end
            gam_pkg::ST_CMP: begin
                if (better) begin
                    best_reg    <= v_reg;
                    min_row_reg <= ptr_reg;
                    min_a_reg   <= a_reg;
                    have_reg    <= 1'b1;
                end
                remain_reg <= remain_reg - 11'd1;
                ptr_reg    <= (ptr_reg == LAST_ROW) ? '0 : ptr_reg + 1'b1;
            end
            gam_pkg::ST_GRAD_WAIT: begin
                if (div_done) begin
                    grad_reg <= gam_pkg::sat32(65'(div_quo));
                end
            end
            gam_pkg::ST_EMIT: begin
                if (emit_fire) begin
                    g_reg <= g_reg + 7'd1;
                    m_data_reg.group_number <= g_reg[5:0];
                    m_data_reg.last         <= (g_reg + 7'd1 == ng_reg);
                    m_data_reg.empty_group  <= empty_reg;
                    if (empty_reg) begin
                        m_data_reg.constraint_value <= gam_pkg::VALUE_MAX;
                        m_data_reg.gradient         <= 32'sd0;
                        m_data_reg.min_row_index    <= 10'd0;
                    end else begin
                        m_data_reg.constraint_value <= gam_pkg::sat32(best_reg);
                        m_data_reg.gradient         <= grad_reg;
                        m_data_reg.min_row_index    <= 10'(min_row_reg);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ test/tb_grouped_affine_min_eval.sv @@
// Self-checking testbench for grouped_affine_min_eval: a directed table, then random
// phases with random idling on both channels, checked against a behavioral predictor.
// Depends on gam_pkg and the block's RTL.
module tb_grouped_affine_min_eval;

    // Rows that the test loads and groups read: a window wrapping past the table end.
    localparam int WIN_BASE = 1020;
    localparam int WIN_SIZE = 20;

    typedef struct {
        bit                 is_cfg;
        logic [1:0]         reg_idx;
        logic [31:0]        wdata;
        gam_pkg::gam_in_t   item;
        bit                 typed;
        gam_pkg::gam_out_t  exp_res;
    } plan_step_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    gam_pkg::gam_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    gam_pkg::gam_out_t m_data;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = gam_pkg::REG_GROUPS_IN_USE;
    logic [31:0] cfg_wr_data = '0;

    grouped_affine_min_eval dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state.
    logic signed [31:0] row_slope [1024];
    logic signed [31:0] row_offset [1024];
    logic [9:0]         grp_start [64];
    logic [10:0]        grp_count [64];
    logic [6:0]         cfg_groups;
    logic signed [31:0] cfg_center;
    logic signed [31:0] cfg_gen;

    gam_pkg::gam_out_t expected_results [$];
    plan_step_t plan [$];
    int  mismatches = 0;
    bit  valid_on = 0;
    int  next_gap = 0;
    bit  no_idle = 0;
    bit  hold_req = 0;
    bit  cfg_open = 0;

    function automatic logic signed [31:0] sat_q(input longint x);
        if (x > longint'(gam_pkg::VALUE_MAX)) return gam_pkg::VALUE_MAX;
        if (x < longint'(gam_pkg::VALUE_MIN)) return gam_pkg::VALUE_MIN;
        return x[31:0];
    endfunction

    function automatic longint quot(input longint num, input longint den);
        if (den == 0) return 0;
        return num / den;
    endfunction

    function automatic int win_row(input int k);
        return (WIN_BASE + k) % 1024;
    endfunction

    function automatic gam_pkg::gam_in_t mk_item(input logic [1:0] op, input int idx,
                                                 input int a, input int b,
                                                 input int first, input int cnt,
                                                 input int val);
        gam_pkg::gam_in_t it;
        it.opcode = op;
        it.entry_index = 10'(idx);
        it.coef_a = a;
        it.offset_b = b;
        it.group_first_row = 10'(first);
        it.group_row_count = 11'(cnt);
        it.eval_value = val;
        return it;
    endfunction

    // Applies an accepted item to the predictor; with push_res, queues its results.
    task automatic predict_item(input gam_pkg::gam_in_t it, input bit push_res);
        longint d, q, v, best;
        int ng, r, min_row;
        bit have;
        gam_pkg::gam_out_t res;
        case (it.opcode)
            gam_pkg::OP_LOAD_ROW: begin
                row_slope[it.entry_index] = it.coef_a;
                row_offset[it.entry_index] = it.offset_b;
            end
            gam_pkg::OP_LOAD_GROUP: begin
                if (it.entry_index < 64) begin
                    grp_start[it.entry_index] = it.group_first_row;
                    grp_count[it.entry_index] = it.group_row_count;
                end
            end
            gam_pkg::OP_EVAL: begin
                d = longint'(it.eval_value) - longint'(cfg_center);
                ng = (cfg_groups > 64) ? 64 : cfg_groups;
                for (int g = 0; g < ng; g++) begin
                    res = '0;
                    res.group_number = 6'(g);
                    res.last = (g + 1 == ng);
                    if (grp_count[g] == 0) begin
                        res.constraint_value = gam_pkg::VALUE_MAX;
                        res.empty_group = 1'b1;
                    end else begin
                        have = 0;
                        best = 0;
                        min_row = 0;
                        for (int k = 0; k < grp_count[g]; k++) begin
                            r = (grp_start[g] + k) % 1024;
                            q = quot(longint'(row_slope[r]) * d, longint'(cfg_gen));
                            v = longint'(row_offset[r]) - q;
                            if (!have || v < best) begin
                                best = v;
                                min_row = r;
                                have = 1;
                            end
                        end
                        res.constraint_value = sat_q(best);
                        res.gradient = sat_q(quot(-(longint'(row_slope[min_row]) * 65536),
                                                  longint'(cfg_gen)));
                        res.min_row_index = 10'(min_row);
                    end
                    if (push_res) expected_results.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(17, 0);
    endfunction

    task automatic send(input gam_pkg::gam_in_t it, input bit typed,
                        input gam_pkg::gam_out_t exp_res);
        if (!valid_on) begin
            repeat ((next_gap == 0) ? 1 : next_gap) @(posedge aclk);
            s_valid <= 1'b1;
            valid_on = 1;
        end
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        predict_item(it, !typed);
        if (typed) expected_results.push_back(exp_res);
        next_gap = draw_gap();
        if (next_gap > 0) begin
            s_valid <= 1'b0;
            valid_on = 0;
        end
    endtask

    task automatic stop_send();
        if (valid_on) begin
            s_valid <= 1'b0;
            valid_on = 0;
        end
    endtask

    task automatic wait_idle();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        case (idx)
            gam_pkg::REG_GROUPS_IN_USE:   cfg_groups = val[6:0];
            gam_pkg::REG_SLICE_CENTER:    cfg_center = val;
            gam_pkg::REG_SLICE_GENERATOR: cfg_gen = val;
            default: ;
        endcase
    endtask

    task automatic run_step(input plan_step_t st);
        if (st.is_cfg) begin
            if (!cfg_open) begin
                stop_send();
                wait_idle();
                cfg_open = 1;
            end
            write_reg(st.reg_idx, st.wdata);
        end else begin
            if (cfg_open) begin
                cfg_wr_en <= 1'b0;
                cfg_open = 0;
            end
            send(st.item, st.typed, st.exp_res);
        end
    endtask

    function automatic plan_step_t cfg_step(input logic [1:0] idx, input logic [31:0] val);
        plan_step_t st;
        st = '{1'b1, idx, val, '0, 1'b0, '0};
        return st;
    endfunction

    function automatic plan_step_t item_step(input gam_pkg::gam_in_t it);
        plan_step_t st;
        st = '{1'b0, gam_pkg::REG_GROUPS_IN_USE, '0, it, 1'b0, '0};
        return st;
    endfunction

    function automatic plan_step_t typed_step(input gam_pkg::gam_in_t it,
                                              input gam_pkg::gam_out_t e);
        plan_step_t st;
        st = '{1'b0, gam_pkg::REG_GROUPS_IN_USE, '0, it, 1'b1, e};
        return st;
    endfunction

    // Result side: random stalls, one long hold-off on request, field-wise checking.
    initial begin : result_side
        int stall;
        gam_pkg::gam_out_t e;
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else begin
                stall = draw_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer: %h", m_data);
            end else begin
                e = expected_results.pop_front();
                if (m_data.group_number !== e.group_number ||
                    m_data.constraint_value !== e.constraint_value ||
                    m_data.gradient !== e.gradient ||
                    m_data.min_row_index !== e.min_row_index ||
                    m_data.empty_group !== e.empty_group ||
                    m_data.last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", e, m_data);
                end
            end
        end
    end

    initial begin : stimulus
        gam_pkg::gam_in_t it;
        int groups, evals, pick;
        logic [31:0] gen;
        logic [31:0] val_a, val_b;
        cfg_groups = 0;
        cfg_center = 0;
        cfg_gen = gam_pkg::GEN_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: no groups in use, so this evaluation gives nothing.
        send(mk_item(gam_pkg::OP_EVAL, 0, 0, 0, 0, 0, 32'h1234_5678), 0, '0);
        send(mk_item(gam_pkg::OP_RESERVED, 10'h3FF, '1, '1, '1, '1, '1), 0, '0);

        // Fill the row window and every group, with groups kept inside the window.
        for (int k = 0; k < WIN_SIZE; k++)
            send(mk_item(gam_pkg::OP_LOAD_ROW, win_row(k), $urandom, $urandom, 0, 0, 0),
                 0, '0);
        for (int g = 0; g < 64; g++)
            send(mk_item(gam_pkg::OP_LOAD_GROUP, g, 0, 0, win_row($urandom_range(16, 0)),
                         $urandom_range(3, 0), 0), 0, '0);

        plan.push_back(cfg_step(gam_pkg::REG_GROUPS_IN_USE, 1));
        plan.push_back(cfg_step(gam_pkg::REG_SLICE_CENTER, 0));
        plan.push_back(cfg_step(gam_pkg::REG_SLICE_GENERATOR, gam_pkg::GEN_RESET));
        plan.push_back(item_step(mk_item(gam_pkg::OP_LOAD_ROW, 5, 0, 100, 0, 0, 0)));
        plan.push_back(item_step(mk_item(gam_pkg::OP_LOAD_GROUP, 0, 0, 0, 5, 1, 0)));
        plan.push_back(typed_step(mk_item(gam_pkg::OP_EVAL, 0, 0, 0, 0, 0,
                                          gam_pkg::VALUE_MAX),
                                  '{6'd0, 32'sd100, 32'sd0, 10'd5, 1'b0, 1'b1}));
        // Empty group.
        plan.push_back(item_step(mk_item(gam_pkg::OP_LOAD_GROUP, 0, 0, 0, 5, 0, 0)));
        plan.push_back(typed_step(mk_item(gam_pkg::OP_EVAL, 0, 0, 0, 0, 0, 0),
                                  '{6'd0, gam_pkg::VALUE_MAX, 32'sd0, 10'd0, 1'b1, 1'b1}));
        // Group running past the table end, with extreme coefficients.
        plan.push_back(item_step(mk_item(gam_pkg::OP_LOAD_ROW, 1023, gam_pkg::VALUE_MIN,
                                         gam_pkg::VALUE_MAX, 0, 0, 0)));
        plan.push_back(item_step(mk_item(gam_pkg::OP_LOAD_ROW, 0, gam_pkg::VALUE_MAX,
                                         gam_pkg::VALUE_MIN, 0, 0, 0)));
        plan.push_back(item_step(mk_item(gam_pkg::OP_LOAD_GROUP, 0, 0, 0, 1023, 2, 0)));
        plan.push_back(item_step(mk_item(gam_pkg::OP_EVAL, 0, 0, 0, 0, 0,
                                         gam_pkg::VALUE_MIN)));
        // Group index out of the table and unknown opcode are both dropped.
        plan.push_back(item_step(mk_item(gam_pkg::OP_LOAD_GROUP, 1023, 0, 0, 0,
                                         11'h7FF, 0)));
        plan.push_back(item_step(mk_item(gam_pkg::OP_RESERVED, 0, 0, 0, 0, 0, 0)));
        // Zero generator: the slope term vanishes, so the lower offset wins.
        plan.push_back(cfg_step(gam_pkg::REG_SLICE_GENERATOR, 0));
        plan.push_back(typed_step(mk_item(gam_pkg::OP_EVAL, 0, 0, 0, 0, 0, 32'h0001_0000),
                                  '{6'd0, gam_pkg::VALUE_MIN, 32'sd0, 10'd0, 1'b0, 1'b1}));
        plan.push_back(cfg_step(gam_pkg::REG_SLICE_GENERATOR, 32'hFFFF_FFFF));
        plan.push_back(cfg_step(gam_pkg::REG_SLICE_CENTER, gam_pkg::VALUE_MIN));
        plan.push_back(item_step(mk_item(gam_pkg::OP_EVAL, 0, 0, 0, 0, 0,
                                         gam_pkg::VALUE_MAX)));
        // Too many groups is clipped to the table size.
        plan.push_back(cfg_step(gam_pkg::REG_GROUPS_IN_USE, 127));
        plan.push_back(cfg_step(gam_pkg::REG_SLICE_CENTER, gam_pkg::VALUE_MAX));
        plan.push_back(cfg_step(gam_pkg::REG_SLICE_GENERATOR, gam_pkg::VALUE_MIN));
        plan.push_back(item_step(mk_item(gam_pkg::OP_EVAL, 0, 0, 0, 0, 0, 0)));
        // One group spanning every loaded row, wrapping past the table end.
        plan.push_back(cfg_step(gam_pkg::REG_GROUPS_IN_USE, 2));
        plan.push_back(cfg_step(gam_pkg::REG_SLICE_CENTER, 0));
        plan.push_back(cfg_step(gam_pkg::REG_SLICE_GENERATOR, gam_pkg::GEN_RESET));
        plan.push_back(item_step(mk_item(gam_pkg::OP_LOAD_GROUP, 1, 0, 0, WIN_BASE,
                                         WIN_SIZE, 0)));
        plan.push_back(item_step(mk_item(gam_pkg::OP_EVAL, 0, 0, 0, 0, 0, $urandom)));
        plan.push_back(item_step(mk_item(gam_pkg::OP_LOAD_GROUP, 1, 0, 0, 7, 2, 0)));

        foreach (plan[i]) run_step(plan[i]);

        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(7, 0))
                0: groups = 0;
                1: groups = 1;
                2: groups = 2;
                3: groups = 3;
                4: groups = 5;
                5: groups = 8;
                6: groups = 64;
                default: groups = 100;
            endcase
            if (ph == 1) groups = 4;
            case ($urandom_range(7, 0))
                0: gen = 0;
                1: gen = 1;
                2: gen = 32'hFFFF_FFFF;
                3: gen = gam_pkg::VALUE_MIN;
                4: gen = gam_pkg::VALUE_MAX;
                5: gen = $urandom_range(32'h0004_0000, 1);
                6: gen = $urandom;
                default: gen = gam_pkg::GEN_RESET;
            endcase
            run_step(cfg_step(gam_pkg::REG_GROUPS_IN_USE, groups));
            run_step(cfg_step(gam_pkg::REG_SLICE_CENTER, ($urandom_range(3, 0) == 0) ?
                                               gam_pkg::VALUE_MAX : $urandom));
            run_step(cfg_step(gam_pkg::REG_SLICE_GENERATOR, gen));
            no_idle = (ph % 3 == 2);
            // The long receiver hold-off lands while loads keep arriving.
            if (ph == 1) hold_req = 1;
            evals = 0;
            for (int n = 0; n < 22; n++) begin
                pick = $urandom_range(99, 0);
                val_a = ($urandom_range(7, 0) == 0) ? gam_pkg::VALUE_MIN : $urandom;
                val_b = ($urandom_range(7, 0) == 0) ? gam_pkg::VALUE_MAX : $urandom;
                if (pick >= 60 && groups >= 64 && evals >= 2) pick = 0;
                if (pick < 40)
                    it = mk_item(gam_pkg::OP_LOAD_ROW, win_row($urandom_range(WIN_SIZE - 1, 0)),
                                 val_a, val_b, $urandom, $urandom, $urandom);
                else if (pick < 50)
                    it = mk_item(gam_pkg::OP_LOAD_GROUP, $urandom_range(63, 0), $urandom,
                                 $urandom, win_row($urandom_range(15, 0)),
                                 $urandom_range(4, 0), $urandom);
                else if (pick < 55)
                    it = mk_item(gam_pkg::OP_LOAD_GROUP, $urandom_range(1023, 64), $urandom,
                                 $urandom, $urandom, $urandom_range(2047, 0), $urandom);
                else if (pick < 60)
                    it = mk_item(gam_pkg::OP_RESERVED, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom);
                else begin
                    it = mk_item(gam_pkg::OP_EVAL, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, val_b);
                    evals++;
                end
                run_step(item_step(it));
            end
        end
        stop_send();
        no_idle = 0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #30000000;
        $display("simulation failed");
        $finish;
    end

endmodule
